// ===== rtl/csm_pkg.sv =====
// ----------------------------------------------------------------------------
// csm_pkg
// Shared types and constants of the CSR sparse matrix-vector block: item
// kinds, register indexes, controller states and multiplier status.
// ----------------------------------------------------------------------------
package csm_pkg;

  localparam int ROW_W     = 16;
  localparam int IDX_W     = 10;
  localparam int NCOL_W    = 11;
  localparam int ACC_W     = 64;
  localparam int FRAC_BITS = 16;
  localparam int CFG_IDX_W = 2;
  localparam int EXT_IDX_W = 17;

  localparam logic [NCOL_W-1:0] NUM_COLS_RST = 11'd1024;
  localparam int                SCALE_RST    = 65536;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE    = 2'd2;

  typedef enum logic [1:0] {
    KIND_START = 2'd0,
    KIND_LOAD  = 2'd1,
    KIND_NZ    = 2'd2,
    KIND_EMPTY = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_MUL,
    ST_FIN,
    ST_SCL,
    ST_SMUL,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic done;
    logic sat;
  } mul_stat_t;

endpackage

// ===== rtl/csr_sparse_matvec.sv =====
// ----------------------------------------------------------------------------
// csr_sparse_matvec
// Compressed-sparse-row matrix times vector in Q16.16 with a saturating row
// accumulator, an optional scaled accumulate mode and column range checks.
// ----------------------------------------------------------------------------
// Items are processed one at a time. A nonzero beat goes through one vector
// store read and the split multiplier ahead of the accumulator add. A nonzero
// whose column is out of range skips the read and the multiplier. In mode 1,
// closing a row also runs the same multiplier to apply the scale. A finished
// result waits in the output register while the next beats come in; only the
// next row end waits on it.
module csr_sparse_matvec #(
  parameter int VECTOR_DEPTH = 1024,
  parameter int VALUE_BITS   = 32
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic [1:0]                           in_kind,
  input  logic [csm_pkg::IDX_W-1:0]            in_vector_index,
  input  logic signed [VALUE_BITS-1:0]         in_vector_value,
  input  logic [csm_pkg::IDX_W-1:0]            in_column,
  input  logic signed [VALUE_BITS-1:0]         in_nz_value,
  input  logic                                 in_last_in_row,
  input  logic signed [VALUE_BITS-1:0]         in_old_value,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic [csm_pkg::ROW_W-1:0]            out_row_index,
  output logic signed [VALUE_BITS-1:0]         out_row_value,
  output logic                                 out_column_fault,
  output logic                                 out_overflow,
  input  logic                                 cfg_wr_en,
  input  logic [csm_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [((VALUE_BITS > 11) ? VALUE_BITS : 11)-1:0] cfg_data
);

  localparam int VB     = VALUE_BITS;
  localparam int ADDR_W = $clog2(VECTOR_DEPTH);
  localparam int XW     = csm_pkg::EXT_IDX_W;
  localparam logic [XW-1:0] DEPTH_X = XW'(VECTOR_DEPTH);

  function automatic logic [VB:0] clamp_fn(input logic [63:0] x);
    logic same;
    logic [VB:0] r;
    same = (&x[63:VB-1]) | ~(|x[63:VB-1]);
    if (same) begin
      r = {1'b0, x[VB-1:0]};
    end else if (x[63]) begin
      r = {1'b1, 1'b1, {(VB - 1){1'b0}}};
    end else begin
      r = {1'b1, 1'b0, {(VB - 1){1'b1}}};
    end
    return r;
  endfunction

  csm_pkg::state_t state_r;
  csm_pkg::state_t state_nxt;
  csm_pkg::kind_t  kind;

  logic [csm_pkg::NCOL_W-1:0]       num_cols_r;
  logic                             mode_r;
  logic signed [VB-1:0]             scale_r;

  logic signed [63:0]               acc_r;
  logic                             acc_sat_r;
  logic                             fault_r;
  logic [csm_pkg::ROW_W-1:0]        row_cnt_r;
  logic signed [VB-1:0]             nz_r;
  logic signed [VB-1:0]             old_r;
  logic                             last_r;
  logic signed [VB-1:0]             s_r;
  logic                             ovf_r;

  logic                             out_valid_r;
  logic [csm_pkg::ROW_W-1:0]        out_row_index_r;
  logic signed [VB-1:0]             out_row_value_r;
  logic                             out_fault_r;
  logic                             out_ovf_r;

  logic [XW-1:0]                    col_x;
  logic [XW-1:0]                    vidx_x;
  logic                             col_ok;
  logic                             load_ok;
  logic                             take;
  logic                             out_free;

  logic                             mem_we;
  logic                             mem_re;
  logic [VB-1:0]                    rd_data;
  logic                             mul_start;
  logic signed [VB-1:0]             mul_a;
  logic signed [VB-1:0]             mul_b;
  logic signed [63:0]               mul_p;
  csm_pkg::mul_stat_t               mul_stat;

  logic                             do_start;
  logic                             do_fault;
  logic                             do_acc;
  logic                             do_fin;
  logic                             do_smul;
  logic                             do_emit;

  logic [64:0]                      sum65;
  logic signed [63:0]               acc_nxt;
  logic                             acc_ovf;
  logic [VB:0]                      fin_c;
  logic signed [63:0]               t_val;
  logic [VB:0]                      t_c;

  assign kind     = csm_pkg::kind_t'(in_kind);
  assign col_x    = {{(XW - csm_pkg::IDX_W){1'b0}}, in_column};
  assign vidx_x   = {{(XW - csm_pkg::IDX_W){1'b0}}, in_vector_index};
  assign col_ok   = ({1'b0, in_column} < num_cols_r) && (col_x < DEPTH_X);
  assign load_ok  = vidx_x < DEPTH_X;
  assign in_ready = (state_r == csm_pkg::ST_IDLE);
  assign take     = in_valid & in_ready;
  assign out_free = ~out_valid_r | out_ready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      csm_pkg::ST_IDLE: begin
        if (in_valid) begin
          unique case (kind)
            csm_pkg::KIND_NZ: begin
              if (col_ok) begin
                state_nxt = csm_pkg::ST_READ;
              end else if (in_last_in_row) begin
                state_nxt = csm_pkg::ST_FIN;
              end
            end
            csm_pkg::KIND_EMPTY: state_nxt = csm_pkg::ST_FIN;
            default:             state_nxt = csm_pkg::ST_IDLE;
          endcase
        end
      end
      csm_pkg::ST_READ: state_nxt = csm_pkg::ST_MUL;
      csm_pkg::ST_MUL: begin
        if (mul_stat.done) begin
          state_nxt = last_r ? csm_pkg::ST_FIN : csm_pkg::ST_IDLE;
        end
      end
      csm_pkg::ST_FIN:  state_nxt = mode_r ? csm_pkg::ST_SCL : csm_pkg::ST_EMIT;
      csm_pkg::ST_SCL:  state_nxt = csm_pkg::ST_SMUL;
      csm_pkg::ST_SMUL: begin
        if (mul_stat.done) begin
          state_nxt = csm_pkg::ST_EMIT;
        end
      end
      csm_pkg::ST_EMIT: begin
        if (out_free) begin
          state_nxt = csm_pkg::ST_IDLE;
        end
      end
      default: state_nxt = csm_pkg::ST_IDLE;
    endcase
  end

  // Controller outputs.
  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    do_start  = 1'b0;
    do_fault  = 1'b0;
    if (take) begin
      unique case (kind)
        csm_pkg::KIND_START: do_start = 1'b1;
        csm_pkg::KIND_LOAD:  mem_we   = load_ok;
        csm_pkg::KIND_NZ: begin
          mem_re   = col_ok;
          do_fault = ~col_ok;
        end
        default: ;
      endcase
    end
    mul_start = (state_r == csm_pkg::ST_READ) || (state_r == csm_pkg::ST_SCL);
    mul_a     = (state_r == csm_pkg::ST_READ) ? nz_r : scale_r;
    mul_b     = (state_r == csm_pkg::ST_READ) ? $signed(rd_data) : s_r;
    do_acc    = (state_r == csm_pkg::ST_MUL) && mul_stat.done;
    do_fin    = (state_r == csm_pkg::ST_FIN);
    do_smul   = (state_r == csm_pkg::ST_SMUL) && mul_stat.done;
    do_emit   = (state_r == csm_pkg::ST_EMIT) && out_free;
  end

  // Saturating accumulate, row-end clamp and scaled accumulate.
  always_comb begin
    sum65   = {acc_r[63], acc_r} + {mul_p[63], mul_p};
    acc_ovf = sum65[64] ^ sum65[63];
    if (acc_ovf) begin
      acc_nxt = sum65[64] ? {1'b1, {63{1'b0}}} : {1'b0, {63{1'b1}}};
    end else begin
      acc_nxt = sum65[63:0];
    end
    fin_c = clamp_fn(acc_r >>> csm_pkg::FRAC_BITS);
    t_val = $signed({{(64 - VB){old_r[VB-1]}}, old_r}) + (mul_p >>> csm_pkg::FRAC_BITS);
    t_c   = clamp_fn(t_val);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= csm_pkg::ST_IDLE;
      num_cols_r  <= csm_pkg::NUM_COLS_RST;
      mode_r      <= 1'b0;
      scale_r     <= VB'(csm_pkg::SCALE_RST);
      acc_r       <= '0;
      acc_sat_r   <= 1'b0;
      fault_r     <= 1'b0;
      row_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        unique case (cfg_index)
          csm_pkg::CFG_NUM_COLS: num_cols_r <= cfg_data[csm_pkg::NCOL_W-1:0];
          csm_pkg::CFG_MODE:     mode_r     <= cfg_data[0];
          csm_pkg::CFG_SCALE:    scale_r    <= cfg_data[VB-1:0];
          default: ;
        endcase
      end
      if (do_start || do_emit) begin
        acc_r     <= '0;
        acc_sat_r <= 1'b0;
        fault_r   <= 1'b0;
      end else begin
        if (do_acc) begin
          acc_r     <= acc_nxt;
          acc_sat_r <= acc_sat_r | acc_ovf | mul_stat.sat;
        end
        if (do_fault) begin
          fault_r <= 1'b1;
        end
      end
      if (do_start) begin
        row_cnt_r <= '0;
      end else if (do_emit) begin
        row_cnt_r <= row_cnt_r + 16'd1;
      end
      if (do_emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      nz_r   <= in_nz_value;
      old_r  <= in_old_value;
      last_r <= in_last_in_row;
    end
    if (do_fin) begin
      s_r   <= fin_c[VB-1:0];
      ovf_r <= acc_sat_r | fin_c[VB];
    end else if (do_smul) begin
      s_r   <= t_c[VB-1:0];
      ovf_r <= ovf_r | mul_stat.sat | t_c[VB];
    end
    if (do_emit) begin
      out_row_index_r <= row_cnt_r;
      out_row_value_r <= s_r;
      out_fault_r     <= fault_r;
      out_ovf_r       <= ovf_r;
    end
  end

  csm_vstore #(
    .DEPTH  (VECTOR_DEPTH),
    .DATA_W (VB)
  ) u_vstore (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (vidx_x[ADDR_W-1:0]),
    .wr_data (in_vector_value),
    .rd_en   (mem_re),
    .rd_addr (col_x[ADDR_W-1:0]),
    .rd_data (rd_data)
  );

  csm_mul #(
    .VB (VB)
  ) u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .p     (mul_p),
    .stat  (mul_stat)
  );

  assign out_valid        = out_valid_r;
  assign out_row_index    = out_row_index_r;
  assign out_row_value    = out_row_value_r;
  assign out_column_fault = out_fault_r;
  assign out_overflow     = out_ovf_r;

  a_done_in_mul_state: assert property (@(posedge clk) disable iff (!rst_n)
    mul_stat.done |-> (state_r == csm_pkg::ST_MUL || state_r == csm_pkg::ST_SMUL))
    else $error("multiplier finished outside a wait state");

  a_read_then_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mem_re |=> (state_r == csm_pkg::ST_READ))
    else $error("vector store read not followed by multiply start");

  a_row_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    do_emit |=> (out_valid_r && row_cnt_r == $past(row_cnt_r) + 16'd1))
    else $error("row result not posted with a counter step");

endmodule

// ===== rtl/csm_vstore.sv =====
// ----------------------------------------------------------------------------
// csm_vstore
// Operand vector store: one write port and one read port with registered
// read data.
// ----------------------------------------------------------------------------
module csm_vstore #(
  parameter int DEPTH  = 1024,
  parameter int DATA_W = 32
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [DATA_W-1:0]        wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [DATA_W-1:0]        rd_data
);

  logic [DATA_W-1:0] mem_r [DEPTH];
  logic [DATA_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem_r[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/csm_mul.sv =====
// ----------------------------------------------------------------------------
// csm_mul
// Signed multiplier with saturation to 64 bits. The second operand is split
// into a low and a high half, one partial product per cycle, then summed and
// saturated. Result and status are registered and flagged by done.
// ----------------------------------------------------------------------------
module csm_mul #(
  parameter int VB = 32
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [VB-1:0]    a,
  input  logic signed [VB-1:0]    b,
  output logic signed [63:0]      p,
  output csm_pkg::mul_stat_t      stat
);

  localparam int H     = VB / 2;
  localparam int LO_W  = VB + H + 1;
  localparam int HI_W  = 2 * VB - H;
  localparam int PW    = 2 * VB;
  localparam int EXT_W = (PW > 65) ? PW : 65;

  logic signed [VB-1:0]    a_r;
  logic signed [VB-1:0]    b_r;
  logic [3:0]              ph_r;
  logic signed [LO_W-1:0]  lo_r;
  logic signed [HI_W-1:0]  hi_r;
  logic signed [63:0]      p_r;
  logic                    sat_r;

  logic signed [LO_W-1:0]  lo_a;
  logic signed [LO_W-1:0]  lo_b;
  logic signed [LO_W-1:0]  lo_nxt;
  logic signed [HI_W-1:0]  hi_a;
  logic signed [HI_W-1:0]  hi_b;
  logic signed [HI_W-1:0]  hi_nxt;
  logic signed [EXT_W-1:0] full;
  logic signed [EXT_W-1:0] max_c;
  logic signed [EXT_W-1:0] min_c;
  logic                    pos_ovf;
  logic                    neg_ovf;
  logic signed [63:0]      p_nxt;

  always_comb begin
    lo_a   = {{(H + 1){a_r[VB-1]}}, a_r};
    lo_b   = {{VB{1'b0}}, 1'b0, b_r[H-1:0]};
    lo_nxt = lo_a * lo_b;
    hi_a   = {{(HI_W - VB){a_r[VB-1]}}, a_r};
    hi_b   = {{(HI_W - VB + H){b_r[VB-1]}}, b_r[VB-1:H]};
    hi_nxt = hi_a * hi_b;
  end

  always_comb begin
    full    = {{(EXT_W - LO_W){lo_r[LO_W-1]}}, lo_r}
            + ({{(EXT_W - HI_W){hi_r[HI_W-1]}}, hi_r} <<< H);
    max_c   = {{(EXT_W - 63){1'b0}}, {63{1'b1}}};
    min_c   = {{(EXT_W - 63){1'b1}}, {63{1'b0}}};
    pos_ovf = full > max_c;
    neg_ovf = full <= min_c;
    if (pos_ovf) begin
      p_nxt = {1'b0, {63{1'b1}}};
    end else if (neg_ovf) begin
      p_nxt = {1'b1, {63{1'b0}}};
    end else begin
      p_nxt = full[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r <= '0;
    end else begin
      ph_r <= {ph_r[2:0], start};
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      a_r <= a;
      b_r <= b;
    end
    if (ph_r[0]) begin
      lo_r <= lo_nxt;
    end
    if (ph_r[1]) begin
      hi_r <= hi_nxt;
    end
    if (ph_r[2]) begin
      p_r   <= p_nxt;
      sat_r <= pos_ovf | neg_ovf;
    end
  end

  assign p         = p_r;
  assign stat.done = ph_r[3];
  assign stat.sat  = sat_r;

endmodule
